[hdl/line_follower_pid_drive_assert.svh]
// Assertion macros for the line follower PID drive.
// Needs nothing else; included by the top level only.
`ifndef LINE_FOLLOWER_PID_DRIVE_ASSERT_SVH
`define LINE_FOLLOWER_PID_DRIVE_ASSERT_SVH

// Check that a consequent holds in the same cycle as its antecedent
`define LFPD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds at every edge out of reset
`define LFPD_ASSERT_ALW(label, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cons)) \
      else $error(msg);

`endif

[hdl/lfpd_pkg.sv]
// Shared constants and types for the line follower PID drive.
// No dependencies; used by line_follower_pid_drive.
package lfpd_pkg;

   // Default fixed-point and integral settings
   localparam int FracBitsDefault      = 8;
   localparam int IntegralLimitDefault = 65535;

   // Register map, one register per 32-bit slot
   typedef enum logic [1:0] {
      RegBaseSpeed = 2'd0,
      RegGainP     = 2'd1,
      RegGainI     = 2'd2,
      RegGainD     = 2'd3
   } reg_index_type;

   localparam int RegAddrW = 4;

   // Register reset values
   localparam logic [7:0] BaseSpeedReset = 8'd190;
   localparam logic [7:0] GainPReset     = 8'd20;
   localparam logic [7:0] GainIReset     = 8'd5;
   localparam logic [7:0] GainDReset     = 8'd3;

   // Side where the line was last seen
   typedef enum logic [1:0] {
      SideNone  = 2'd0,
      SideRight = 2'd1,
      SideLeft  = 2'd2
   } side_type;

   localparam logic [7:0] DutyFull = 8'd255;

endpackage

[hdl/line_follower_pid_drive.sv]
// Line follower PID drive: bit-serial sensor scan, divider and multiplier.
// Depends on lfpd_pkg and line_follower_pid_drive_assert.svh.
//
// Usage:
//  - req channel takes one 8-bit sensor snapshot per word (req_valid/req_stall).
//  - rsp channel gives right/left duty, direction bits and line_lost.
//  - APB port holds base_speed, gain_p, gain_i, gain_d at byte offsets 0, 4, 8, 12.
// On the line a result passes through a scan step per sensor bit, a
//  restoring-division step per quotient bit, error and integral steps,
//  a shift-add step of the multiplier per gain bit and one duty step.
// A lost line goes straight to the duty step for its pivot result; a lost
//  line before any side was seen gives no result.
// One word at a time: the next word is taken once the result is in the
//  output register, so a new word is taken while a result waits.
// A stalled rsp holds its word; a finished result waits in the duty step
//  until the output register frees up.
// Reset (synchronous, active high) restores register defaults and clears
//  the error history, the integral and the last seen side.
module line_follower_pid_drive #(
   parameter int FRAC_BITS      = lfpd_pkg::FracBitsDefault,
   parameter int INTEGRAL_LIMIT = lfpd_pkg::IntegralLimitDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   // sensor snapshot in
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_sensors,
   // drive command out
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_right_duty,
   output logic [7:0]                    rsp_left_duty,
   output logic                          rsp_right_reverse,
   output logic                          rsp_left_reverse,
   output logic                          rsp_line_lost,
   // configuration
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lfpd_pkg::RegAddrW-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   // Widths that follow from the parameters
   localparam int EW    = FRAC_BITS + 4;
   localparam int IW    = $clog2(INTEGRAL_LIMIT + 1) + 1;
   localparam int SW    = ((IW > EW) ? IW : EW) + 1;
   localparam int DW    = FRAC_BITS + 6;
   localparam int QW    = FRAC_BITS + 4;
   localparam int CW    = $clog2(255 * (11 * (2 ** FRAC_BITS) + INTEGRAL_LIMIT) + 1) + 2;
   localparam int DutyW = ((CW > FRAC_BITS + 9) ? CW : FRAC_BITS + 9) + 1;
   localparam int CntW  = $clog2(DW);

   localparam logic [CntW-1:0]        ScanLast  = CntW'(7);
   localparam logic [CntW-1:0]        DivLast   = CntW'(DW - 1);
   localparam logic [CntW-1:0]        CntOne    = CntW'(1);
   localparam logic signed [EW:0]     FourOne   = (EW + 1)'(4) <<< FRAC_BITS;
   localparam logic signed [SW-1:0]   IntLimit  = SW'(INTEGRAL_LIMIT);
   localparam logic signed [DutyW-1:0] DutyTop  = DutyW'(255) <<< FRAC_BITS;

   typedef enum logic [5:0] {
      StIdle   = 6'b000001,
      StScan   = 6'b000010,
      StDivide = 6'b000100,
      StError  = 6'b001000,
      StMult   = 6'b010000,
      StDuty   = 6'b100000
   } state_type;

   // Control and datapath registers
   state_type                state_ff, state_in;
   lfpd_pkg::side_type       side_ff, side_in;
   logic [CntW-1:0]          cnt_ff, cnt_in;
   logic [7:0]               sens_ff, sens_in;
   logic [5:0]               sum_ff, sum_in;
   logic [3:0]               count_ff, count_in;
   logic [DW-1:0]            dvd_ff, dvd_in;
   logic [2:0]               rem_ff, rem_in;
   logic [QW-1:0]            quo_ff, quo_in;
   logic signed [EW-1:0]     err_ff, err_in;
   logic signed [EW-1:0]     prev_ff, prev_in;
   logic signed [EW:0]       diff_ff, diff_in;
   logic signed [IW-1:0]     integ_ff, integ_in;
   logic [7:0]               gp_ff, gp_in;
   logic [7:0]               gi_ff, gi_in;
   logic [7:0]               gd_ff, gd_in;
   logic signed [CW-1:0]     acc_ff, acc_in;
   logic                     lost_ff, lost_in;
   logic                     flag_ff, flag_in;

   // Configuration registers
   logic [7:0]               base_ff, gain_p_ff, gain_i_ff, gain_d_ff;

   // Output register
   logic                     out_valid_ff, out_valid_in;
   logic [7:0]               out_right_ff, out_right_in;
   logic [7:0]               out_left_ff, out_left_in;
   logic                     out_rrev_ff, out_rrev_in;
   logic                     out_lrev_ff, out_lrev_in;
   logic                     out_lost_ff, out_lost_in;

   // Combinational helpers
   logic                     accept;
   logic                     out_free;
   logic [3:0]               trial;
   logic                     qbit;
   logic signed [EW:0]       err_wide;
   logic signed [SW-1:0]     integ_sum;
   logic signed [CW-1:0]     term_p, term_i, term_d;
   logic signed [DutyW-1:0]  base_q, right_q, left_q;
   lfpd_pkg::reg_index_type  reg_sel;
   logic                     cfg_write;

   // Clamp a fixed-point duty to 0..255 and drop the fraction
   function automatic logic [7:0] duty_of(input logic signed [DutyW-1:0] q);
      logic [7:0] res;
      if (q <= 0) begin
         res = 8'd0;
      end else if (q >= DutyTop) begin
         res = lfpd_pkg::DutyFull;
      end else begin
         res = q[FRAC_BITS +: 8];
      end
      return res;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != StIdle);

   // Restoring division step: one quotient bit per cycle
   assign trial = {rem_ff, dvd_ff[DW-1]};
   assign qbit  = (trial >= count_ff);

   // Error in Q(FRAC_BITS) from the quotient
   assign err_wide  = $signed({1'b0, quo_ff}) - FourOne;
   assign integ_sum = SW'(integ_ff) + SW'(err_ff);

   // Partial products selected by the current gain bits
   assign term_p = gp_ff[7] ? CW'(err_ff)   : '0;
   assign term_i = gi_ff[7] ? CW'(integ_ff) : '0;
   assign term_d = gd_ff[7] ? CW'(diff_ff)  : '0;

   // Duty sums
   assign base_q  = $signed({{(DutyW - 8 - FRAC_BITS){1'b0}}, base_ff, {FRAC_BITS{1'b0}}});
   assign right_q = base_q + DutyW'(acc_ff);
   assign left_q  = base_q - DutyW'(acc_ff);

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      cnt_in       = cnt_ff;
      sens_in      = sens_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      err_in       = err_ff;
      prev_in      = prev_ff;
      diff_in      = diff_ff;
      integ_in     = integ_ff;
      gp_in        = gp_ff;
      gi_in        = gi_ff;
      gd_in        = gd_ff;
      acc_in       = acc_ff;
      lost_in      = lost_ff;
      flag_in      = flag_ff;
      out_valid_in = out_valid_ff;
      out_right_in = out_right_ff;
      out_left_in  = out_left_ff;
      out_rrev_in  = out_rrev_ff;
      out_lrev_in  = out_lrev_ff;
      out_lost_in  = out_lost_ff;

      // Drop a word the receiver took
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               // Track the side, left wins when both edges see the line
               if (req_sensors[7]) begin
                  side_in = lfpd_pkg::SideLeft;
               end else if (req_sensors[0]) begin
                  side_in = lfpd_pkg::SideRight;
               end
               sens_in  = req_sensors;
               sum_in   = '0;
               count_in = '0;
               cnt_in   = '0;
               if (req_sensors != 8'd0) begin
                  lost_in  = 1'b0;
                  state_in = StScan;
               end else if (side_ff != lfpd_pkg::SideNone) begin
                  lost_in  = 1'b1;
                  flag_in  = (side_ff == lfpd_pkg::SideRight);
                  state_in = StDuty;
               end
            end
         end
         StScan: begin
            // Shift out one sensor bit and weigh it by its index plus one
            if (sens_ff[0]) begin
               sum_in   = sum_ff + 6'(cnt_ff) + 6'd1;
               count_in = count_ff + 4'd1;
            end
            sens_in = {1'b0, sens_ff[7:1]};
            if (cnt_ff == ScanLast) begin
               dvd_in   = {sum_in, {FRAC_BITS{1'b0}}};
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = StDivide;
            end else begin
               cnt_in = cnt_ff + CntOne;
            end
         end
         StDivide: begin
            rem_in = qbit ? 3'(trial - count_ff) : trial[2:0];
            quo_in = {quo_ff[QW-2:0], qbit};
            dvd_in = {dvd_ff[DW-2:0], 1'b0};
            if (cnt_ff == DivLast) begin
               flag_in  = 1'b0;
               state_in = StError;
            end else begin
               cnt_in = cnt_ff + CntOne;
            end
         end
         StError: begin
            // First pass forms the error, second updates history and integral
            if (!flag_ff) begin
               err_in  = err_wide[EW-1:0];
               flag_in = 1'b1;
            end else begin
               if (integ_sum > IntLimit) begin
                  integ_in = IntLimit[IW-1:0];
               end else if (integ_sum < -IntLimit) begin
                  integ_in = IW'(-IntLimit);
               end else begin
                  integ_in = integ_sum[IW-1:0];
               end
               diff_in  = (EW + 1)'(err_ff) - (EW + 1)'(prev_ff);
               prev_in  = err_ff;
               gp_in    = gain_p_ff;
               gi_in    = gain_i_ff;
               gd_in    = gain_d_ff;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = StMult;
            end
         end
         StMult: begin
            // Shift-add, most significant gain bit first
            acc_in = (acc_ff <<< 1) + term_p + term_i + term_d;
            gp_in  = {gp_ff[6:0], 1'b0};
            gi_in  = {gi_ff[6:0], 1'b0};
            gd_in  = {gd_ff[6:0], 1'b0};
            if (cnt_ff == ScanLast) begin
               state_in = StDuty;
            end else begin
               cnt_in = cnt_ff + CntOne;
            end
         end
         StDuty: begin
            // Hold until the output register is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_lost_in  = lost_ff;
               if (lost_ff) begin
                  out_right_in = lfpd_pkg::DutyFull;
                  out_left_in  = lfpd_pkg::DutyFull;
                  out_rrev_in  = flag_ff;
                  out_lrev_in  = !flag_ff;
               end else begin
                  out_right_in = duty_of(right_q);
                  out_left_in  = duty_of(left_q);
                  out_rrev_in  = 1'b0;
                  out_lrev_in  = 1'b0;
               end
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // Sequencer and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         side_ff      <= lfpd_pkg::SideNone;
         prev_ff      <= '0;
         integ_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         prev_ff      <= prev_in;
         integ_ff     <= integ_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath and output payload registers
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      sens_ff      <= sens_in;
      sum_ff       <= sum_in;
      count_ff     <= count_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      err_ff       <= err_in;
      diff_ff      <= diff_in;
      gp_ff        <= gp_in;
      gi_ff        <= gi_in;
      gd_ff        <= gd_in;
      acc_ff       <= acc_in;
      lost_ff      <= lost_in;
      flag_ff      <= flag_in;
      out_right_ff <= out_right_in;
      out_left_ff  <= out_left_in;
      out_rrev_ff  <= out_rrev_in;
      out_lrev_ff  <= out_lrev_in;
      out_lost_ff  <= out_lost_in;
   end

   // Configuration registers, low byte kept
   assign reg_sel   = lfpd_pkg::reg_index_type'(paddr[3:2]);
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= lfpd_pkg::BaseSpeedReset;
         gain_p_ff <= lfpd_pkg::GainPReset;
         gain_i_ff <= lfpd_pkg::GainIReset;
         gain_d_ff <= lfpd_pkg::GainDReset;
      end else if (cfg_write) begin
         unique case (reg_sel)
            lfpd_pkg::RegBaseSpeed: base_ff   <= pwdata[7:0];
            lfpd_pkg::RegGainP:     gain_p_ff <= pwdata[7:0];
            lfpd_pkg::RegGainI:     gain_i_ff <= pwdata[7:0];
            lfpd_pkg::RegGainD:     gain_d_ff <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Register readback
   always_comb begin
      unique case (reg_sel)
         lfpd_pkg::RegBaseSpeed: prdata = {24'd0, base_ff};
         lfpd_pkg::RegGainP:     prdata = {24'd0, gain_p_ff};
         lfpd_pkg::RegGainI:     prdata = {24'd0, gain_i_ff};
         lfpd_pkg::RegGainD:     prdata = {24'd0, gain_d_ff};
         default:                prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // Drive the result channel
   assign rsp_valid         = out_valid_ff;
   assign rsp_right_duty    = out_right_ff;
   assign rsp_left_duty     = out_left_ff;
   assign rsp_right_reverse = out_rrev_ff;
   assign rsp_left_reverse  = out_lrev_ff;
   assign rsp_line_lost     = out_lost_ff;

   // Checks on the sequencer and datapath
`include "line_follower_pid_drive_assert.svh"

   `LFPD_ASSERT_IMP(a_pivot_shape, out_valid_ff && out_lost_ff,
      (out_right_ff == lfpd_pkg::DutyFull) && (out_left_ff == lfpd_pkg::DutyFull)
      && (out_rrev_ff != out_lrev_ff), "pivot word with wrong duty or direction")
   `LFPD_ASSERT_IMP(a_forward_on_line, out_valid_ff && !out_lost_ff,
      !out_rrev_ff && !out_lrev_ff, "reverse bit set while on the line")
   `LFPD_ASSERT_IMP(a_divisor_nonzero, state_ff == StDivide,
      count_ff != 4'd0, "division started with no active sensor")
   `LFPD_ASSERT_ALW(a_integral_bound,
      (SW'(integ_ff) <= IntLimit) && (SW'(integ_ff) >= -IntLimit),
      "integral outside its limit")

endmodule
